### rtl/core/swps_pkg.sv
// servo wag pattern sequencer: shared types, register indexes, mode codes
// and reset values; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package swps_pkg;

  localparam int unsigned AngleW   = 8;
  localparam int unsigned OffsetW  = 9;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned CountW   = 8;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned SumW     = 11;

  localparam logic [AngleW-1:0] AngleMax = 8'd180;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_ENABLED         = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_UPDATE_INTERVAL = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CENTER_ANGLE    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_WAG_OFFSET      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SIDE_TICKS      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_REST_TICKS      = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_WAG_LIMIT       = 3'd6;

  // mode codes
  localparam logic [ModeW-1:0] MODE_CENTER   = 2'd0;
  localparam logic [ModeW-1:0] MODE_HOLD     = 2'd1;
  localparam logic [ModeW-1:0] MODE_WAG      = 2'd2;
  localparam logic [ModeW-1:0] MODE_INTERVAL = 2'd3;

  // reset values
  localparam logic                       RST_ENABLED         = 1'b1;
  localparam logic [TimeW-1:0]           RST_UPDATE_INTERVAL = 16'd0;
  localparam logic [AngleW-1:0]          RST_CENTER_ANGLE    = 8'd90;
  localparam logic signed [OffsetW-1:0]  RST_WAG_OFFSET      = 9'sd30;
  localparam logic [TimeW-1:0]           RST_SIDE_TICKS      = 16'd200;
  localparam logic [TimeW-1:0]           RST_REST_TICKS      = 16'd1000;
  localparam logic [CountW-1:0]          RST_WAG_LIMIT       = 8'd3;

  typedef struct packed {
    logic                      enabled;
    logic [TimeW-1:0]          update_interval;
    logic [AngleW-1:0]         center_angle;
    logic signed [OffsetW-1:0] wag_offset;
    logic [TimeW-1:0]          side_ticks;
    logic [TimeW-1:0]          rest_ticks;
    logic [CountW-1:0]         wag_limit;
  } swps_cfg_t;

  function automatic logic [AngleW-1:0] clamp_angle(input logic signed [SumW-1:0] a);
    logic [AngleW-1:0] r;
    if (a < 0) begin
      r = '0;
    end else if (a > $signed({3'b000, AngleMax})) begin
      r = AngleMax;
    end else begin
      r = a[AngleW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/swps_if.sv
// valid/ready channel interfaces for the servo wag pattern sequencer
// depends on swps_pkg
`timescale 1ns / 1ps
`default_nettype none

interface swps_in_if import swps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [AngleW-1:0] hold_angle;
  logic              restart;

  modport source (output valid, mode, hold_angle, restart, input ready);
  modport sink   (input valid, mode, hold_angle, restart, output ready);
endinterface

interface swps_out_if import swps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [AngleW-1:0] servo_angle;

  modport source (output valid, servo_angle, input ready);
  modport sink   (input valid, servo_angle, output ready);
endinterface

interface swps_cfg_if import swps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  idx;
  logic [CfgDataW-1:0] wdata;

  modport source (output valid, idx, wdata, input ready);
  modport sink   (input valid, idx, wdata, output ready);
endinterface

`default_nettype wire

### rtl/core/swps_cfg_regs.sv
// configuration register file of the servo wag pattern sequencer
// depends on swps_pkg and swps_cfg_if
`timescale 1ns / 1ps
`default_nettype none

module swps_cfg_regs import swps_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  swps_cfg_if.sink    cfg_chan,
  output swps_cfg_t   cfg
);

  swps_cfg_t cfg_r;
  swps_cfg_t cfg_nxt;

  assign cfg_chan.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.idx)
        REG_ENABLED:         cfg_nxt.enabled         = cfg_chan.wdata[0];
        REG_UPDATE_INTERVAL: cfg_nxt.update_interval = cfg_chan.wdata[TimeW-1:0];
        REG_CENTER_ANGLE:    cfg_nxt.center_angle    = cfg_chan.wdata[AngleW-1:0];
        REG_WAG_OFFSET:      cfg_nxt.wag_offset      = $signed(cfg_chan.wdata[OffsetW-1:0]);
        REG_SIDE_TICKS:      cfg_nxt.side_ticks      = cfg_chan.wdata[TimeW-1:0];
        REG_REST_TICKS:      cfg_nxt.rest_ticks      = cfg_chan.wdata[TimeW-1:0];
        REG_WAG_LIMIT:       cfg_nxt.wag_limit       = cfg_chan.wdata[CountW-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled         <= RST_ENABLED;
      cfg_r.update_interval <= RST_UPDATE_INTERVAL;
      cfg_r.center_angle    <= RST_CENTER_ANGLE;
      cfg_r.wag_offset      <= RST_WAG_OFFSET;
      cfg_r.side_ticks      <= RST_SIDE_TICKS;
      cfg_r.rest_ticks      <= RST_REST_TICKS;
      cfg_r.wag_limit       <= RST_WAG_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/servo_wag_pattern_sequencer.sv
// servo wag pattern sequencer top level: input register, tick logic and
// two-entry result buffer; depends on swps_pkg, swps_if and swps_cfg_regs
//
// usage:
//   in_chan  - one item per millisecond tick: mode, hold_angle, restart
//   out_chan - one servo_angle item for each tick that fires an update
//   cfg_chan - register writes (idx, wdata), always ready, idle-time only
// an item is registered on acceptance and evaluated against the countdown
// state; when there is space its result is registered into the output
// register, or into the skid entry while the output register is held.
// one item per cycle is sustained while the receiver keeps up; the limit
// is the single evaluation stage that updates countdowns, side and wag count.
// ticks that give no result still advance the countdowns.
// reset clears countdowns, side and wag count and loads register defaults.
// when the receiver stalls, a skid entry behind the output register holds one
// more result and the input register one more item; only then does
// in_chan.ready drop.
`timescale 1ns / 1ps
`default_nettype none

module servo_wag_pattern_sequencer import swps_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  swps_in_if.sink     in_chan,
  swps_out_if.source  out_chan,
  swps_cfg_if.sink    cfg_chan
);

  swps_cfg_t cfg;

  swps_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  // input register
  logic              s1_valid_r;
  logic [ModeW-1:0]  s1_mode_r;
  logic [AngleW-1:0] s1_hold_r;
  logic              s1_restart_r;

  // tick state
  logic [TimeW-1:0]  update_wait_r, update_wait_nxt;
  logic [TimeW-1:0]  wag_wait_r, wag_wait_nxt;
  logic              wag_side_r, wag_side_nxt;
  logic [CountW-1:0] wags_done_r, wags_done_nxt;

  // result buffer
  logic              out_valid_r, out_valid_nxt;
  logic [AngleW-1:0] out_angle_r, out_angle_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  logic [AngleW-1:0] skid_angle_r, skid_angle_nxt;

  logic [TimeW-1:0]      uw_dec;
  logic [TimeW-1:0]      ww_dec;
  logic [CountW-1:0]     wd_cur;
  logic                  fire;
  logic                  emit;
  logic [AngleW-1:0]     angle;
  logic signed [SumW-1:0] c_ext;
  logic signed [SumW-1:0] o_ext;
  logic [AngleW-1:0]     ang_plus;
  logic [AngleW-1:0]     ang_minus;
  logic [AngleW-1:0]     ang_center;
  logic [AngleW-1:0]     ang_hold;
  logic [AngleW-1:0]     ang_wag;

  logic pop;
  logic space;
  logic s1_adv;
  logic push;
  logic in_acc;

  assign pop    = out_valid_r && out_chan.ready;
  assign space  = !skid_valid_r || pop;
  assign s1_adv = s1_valid_r && (!emit || space);
  assign push   = s1_adv && emit;
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_acc = in_chan.valid && in_chan.ready;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.servo_angle = out_angle_r;

  // angle arithmetic
  assign c_ext      = $signed({3'b000, cfg.center_angle});
  assign o_ext      = SumW'(cfg.wag_offset);
  assign ang_plus   = clamp_angle(c_ext + o_ext);
  assign ang_minus  = clamp_angle(c_ext - o_ext);
  assign ang_center = clamp_angle(c_ext);
  assign ang_hold   = clamp_angle($signed({3'b000, s1_hold_r}));
  assign ang_wag    = wag_side_r ? ang_minus : ang_plus;

  assign uw_dec = (update_wait_r != '0) ? update_wait_r - TimeW'(1) : '0;
  assign ww_dec = (wag_wait_r != '0) ? wag_wait_r - TimeW'(1) : '0;
  assign wd_cur = s1_restart_r ? '0 : wags_done_r;
  assign fire   = cfg.enabled && (uw_dec == '0);

  always_comb begin
    emit            = 1'b0;
    angle           = ang_center;
    update_wait_nxt = uw_dec;
    wag_wait_nxt    = ww_dec;
    wag_side_nxt    = wag_side_r;
    wags_done_nxt   = wd_cur;
    if (fire) begin
      update_wait_nxt = cfg.update_interval;
      case (s1_mode_r)
        MODE_HOLD: begin
          emit  = 1'b1;
          angle = ang_hold;
        end
        MODE_WAG: begin
          if (ww_dec == '0) begin
            emit         = 1'b1;
            angle        = ang_wag;
            wag_wait_nxt = cfg.side_ticks;
            wag_side_nxt = !wag_side_r;
          end
        end
        MODE_INTERVAL: begin
          if (ww_dec == '0) begin
            emit = 1'b1;
            if (wd_cur < cfg.wag_limit) begin
              angle        = ang_wag;
              wag_wait_nxt = cfg.side_ticks;
              wag_side_nxt = !wag_side_r;
              if (!wag_side_r) begin
                wags_done_nxt = wd_cur + CountW'(1);
              end
            end else begin
              angle         = ang_center;
              wag_wait_nxt  = cfg.rest_ticks;
              wags_done_nxt = '0;
            end
          end
        end
        default: begin
          emit  = 1'b1;
          angle = ang_center;
        end
      endcase
    end
  end

  // result buffer steering
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_angle_nxt  = out_angle_r;
    skid_valid_nxt = skid_valid_r;
    skid_angle_nxt = skid_angle_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_angle_nxt  = skid_angle_r;
        skid_valid_nxt = push;
        skid_angle_nxt = angle;
      end else begin
        out_valid_nxt = push;
        out_angle_nxt = angle;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_angle_nxt = angle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      update_wait_r <= '0;
      wag_wait_r    <= '0;
      wag_side_r    <= 1'b0;
      wags_done_r   <= '0;
      out_valid_r   <= 1'b0;
      skid_valid_r  <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (s1_adv) begin
        update_wait_r <= update_wait_nxt;
        wag_wait_r    <= wag_wait_nxt;
        wag_side_r    <= wag_side_nxt;
        wags_done_r   <= wags_done_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r    <= in_chan.mode;
      s1_hold_r    <= in_chan.hold_angle;
      s1_restart_r <= in_chan.restart;
    end
    out_angle_r  <= out_angle_nxt;
    skid_angle_r <= skid_angle_nxt;
  end

endmodule

`default_nettype wire

### verif/servo_wag_pattern_sequencer_test.sv
// self-checking testbench for servo_wag_pattern_sequencer: directed table, then random
// ticks under random register settings; expected angles come from the table or from
// an in-bench angle predictor; depends on swps_pkg, swps_if and the rtl top level
`timescale 1ns / 1ps

module servo_wag_pattern_sequencer_test import swps_pkg::*; ();

  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned QuietLimit    = 1000;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned ItemsPerPhase = 50;

  typedef enum bit [1:0] {CHK_MODEL, CHK_ANGLE, CHK_SILENT} chk_t;
  typedef enum bit {ROW_TICK, ROW_PROGRAM} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [ModeW-1:0]  mode;
    logic [AngleW-1:0] hold;
    logic              restart;
    chk_t              chk;
    logic [AngleW-1:0] angle;
    int                cfg_id;
  } stim_row_t;

  logic clk;
  logic rst_n;

  swps_in_if  in_if ();
  swps_out_if out_if ();
  swps_cfg_if cfg_if ();

  servo_wag_pattern_sequencer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // predictor state and register shadow
  swps_cfg_t         shadow_cfg;
  logic [TimeW-1:0]  upd_left;
  logic [TimeW-1:0]  wag_left;
  logic              side_minus;
  logic [CountW-1:0] wag_count;

  logic [AngleW-1:0] angle_q[$];
  chk_t              row_chk;
  logic [AngleW-1:0] row_angle;

  bit          in_idle_on;
  bit          out_idle_on;
  int unsigned out_hold;
  int unsigned quiet_cycles;
  int unsigned fails;
  int unsigned ticks_seen;
  int unsigned angles_checked;
  int unsigned settings_used;

  stim_row_t dir_rows[$];
  swps_cfg_t dir_cfg[4];

  function automatic logic [AngleW-1:0] sat_angle(input int a);
    if (a < 0) return '0;
    if (a > 180) return AngleMax;
    return AngleW'(a);
  endfunction

  function automatic bit servo_tick(input logic [ModeW-1:0] mode, input logic [AngleW-1:0] hold,
                                    input logic restart, output logic [AngleW-1:0] angle);
    int c;
    int o;
    c = int'(shadow_cfg.center_angle);
    o = int'($signed(shadow_cfg.wag_offset));
    angle = '0;
    if (upd_left != 0) upd_left = upd_left - TimeW'(1);
    if (wag_left != 0) wag_left = wag_left - TimeW'(1);
    if (restart) wag_count = '0;
    if (!shadow_cfg.enabled || upd_left != 0) return 1'b0;
    upd_left = shadow_cfg.update_interval;
    case (mode)
      MODE_HOLD: angle = sat_angle(int'(hold));
      MODE_WAG, MODE_INTERVAL: begin
        if (wag_left != 0) return 1'b0;
        if (mode == MODE_INTERVAL && wag_count >= shadow_cfg.wag_limit) begin
          wag_left  = shadow_cfg.rest_ticks;
          angle     = sat_angle(c);
          wag_count = '0;
        end else begin
          wag_left = shadow_cfg.side_ticks;
          if (side_minus) begin
            angle      = sat_angle(c - o);
            side_minus = 1'b0;
          end else begin
            angle      = sat_angle(c + o);
            side_minus = 1'b1;
            if (mode == MODE_INTERVAL) wag_count = wag_count + CountW'(1);
          end
        end
      end
      default: angle = sat_angle(c);
    endcase
    return 1'b1;
  endfunction

  always @(posedge clk) begin : scoreboard
    logic [AngleW-1:0] want;
    logic [AngleW-1:0] ang;
    bit                has;
    bit                moved;
    if (!rst_n) begin
      shadow_cfg   = '{RST_ENABLED, RST_UPDATE_INTERVAL, RST_CENTER_ANGLE, RST_WAG_OFFSET,
                       RST_SIDE_TICKS, RST_REST_TICKS, RST_WAG_LIMIT};
      upd_left     = '0;
      wag_left     = '0;
      side_minus   = 1'b0;
      wag_count    = '0;
      quiet_cycles = 0;
      angle_q.delete();
    end else begin
      moved = 1'b0;
      if (out_if.valid && out_if.ready) begin
        moved = 1'b1;
        if (angle_q.size() == 0) begin
          $error("servo_angle: no item expected, got %0d", out_if.servo_angle);
          fails++;
        end else begin
          want = angle_q.pop_front();
          if (out_if.servo_angle !== want) begin
            $error("servo_angle: expected %0d, got %0d", want, out_if.servo_angle);
            fails++;
          end
          angles_checked++;
        end
      end
      if (in_if.valid && in_if.ready) begin
        moved = 1'b1;
        has = servo_tick(in_if.mode, in_if.hold_angle, in_if.restart, ang);
        if (row_chk == CHK_ANGLE) begin
          has = 1'b1;
          ang = row_angle;
        end else if (row_chk == CHK_SILENT) begin
          has = 1'b0;
        end
        if (has) angle_q.push_back(ang);
        ticks_seen++;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        moved = 1'b1;
        case (cfg_if.idx)
          REG_ENABLED:         shadow_cfg.enabled         = cfg_if.wdata[0];
          REG_UPDATE_INTERVAL: shadow_cfg.update_interval = cfg_if.wdata;
          REG_CENTER_ANGLE:    shadow_cfg.center_angle    = cfg_if.wdata[AngleW-1:0];
          REG_WAG_OFFSET:      shadow_cfg.wag_offset      = cfg_if.wdata[OffsetW-1:0];
          REG_SIDE_TICKS:      shadow_cfg.side_ticks      = cfg_if.wdata;
          REG_REST_TICKS:      shadow_cfg.rest_ticks      = cfg_if.wdata;
          REG_WAG_LIMIT:       shadow_cfg.wag_limit       = cfg_if.wdata[CountW-1:0];
          default: ;
        endcase
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  // receiver: stall drawn per item
  always @(posedge clk) begin
    if (!rst_n) begin
      out_hold = 0;
      out_if.ready <= 1'b1;
    end else begin
      if (out_if.valid && out_if.ready) begin
        out_hold = out_idle_on ? $urandom_range(0, 7) : 0;
      end else if (out_hold != 0) begin
        out_hold--;
      end
      out_if.ready <= (out_hold == 0);
    end
  end

  initial begin : watchdog
    do @(posedge clk); while (quiet_cycles < QuietLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_tick(input logic [ModeW-1:0] mode, input logic [AngleW-1:0] hold,
                           input logic restart, input chk_t chk, input logic [AngleW-1:0] angle);
    int unsigned gap;
    gap = in_idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= mode;
    in_if.hold_angle <= hold;
    in_if.restart    <= restart;
    row_chk          <= chk;
    row_angle        <= angle;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.idx   <= idx;
    cfg_if.wdata <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic program_regs(input swps_cfg_t c);
    settle();
    put_reg(REG_ENABLED, CfgDataW'(c.enabled));
    put_reg(REG_UPDATE_INTERVAL, c.update_interval);
    put_reg(REG_CENTER_ANGLE, CfgDataW'(c.center_angle));
    put_reg(REG_WAG_OFFSET, CfgDataW'(unsigned'(c.wag_offset)));
    put_reg(REG_SIDE_TICKS, c.side_ticks);
    put_reg(REG_REST_TICKS, c.rest_ticks);
    put_reg(REG_WAG_LIMIT, CfgDataW'(c.wag_limit));
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic add_tick(input logic [ModeW-1:0] mode, input logic [AngleW-1:0] hold,
                          input logic restart, input chk_t chk, input logic [AngleW-1:0] angle);
    dir_rows.push_back('{ROW_TICK, mode, hold, restart, chk, angle, 0});
  endtask

  task automatic add_program(input int id);
    dir_rows.push_back('{ROW_PROGRAM, MODE_CENTER, 8'd0, 1'b0, CHK_MODEL, 8'd0, id});
  endtask

  function automatic swps_cfg_t draw_cfg();
    swps_cfg_t c;
    int        off;
    c.enabled         = ($urandom_range(0, 7) != 0);
    c.update_interval = TimeW'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 10)
                                                            : $urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0:       c.center_angle = 8'd0;
      1:       c.center_angle = AngleMax;
      2:       c.center_angle = AngleW'($urandom_range(0, 255));
      default: c.center_angle = AngleW'($urandom_range(0, 180));
    endcase
    case ($urandom_range(0, 7))
      0:       off = -180;
      1:       off = 180;
      default: off = int'($urandom_range(0, 360)) - 180;
    endcase
    c.wag_offset = OffsetW'(off);
    c.side_ticks = TimeW'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 30)
                                                       : $urandom_range(0, 4));
    c.rest_ticks = TimeW'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 40)
                                                       : $urandom_range(0, 6));
    c.wag_limit  = ($urandom_range(0, 15) == 0) ? 8'd255 : CountW'($urandom_range(0, 4));
    return c;
  endfunction

  initial begin : stimulus
    stim_row_t         r;
    logic [ModeW-1:0]  run_mode;
    logic [ModeW-1:0]  m;
    int unsigned       run_len;
    int unsigned       n;
    int unsigned       k;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.mode       = MODE_CENTER;
    in_if.hold_angle = '0;
    in_if.restart    = 1'b0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.idx       = REG_ENABLED;
    cfg_if.wdata     = '0;
    row_chk          = CHK_MODEL;
    row_angle        = '0;
    in_idle_on       = 1'b1;
    out_idle_on      = 1'b1;

    // low extremes, high extremes, silenced with maximum timers, slow updates
    dir_cfg[0] = '{1'b1, 16'd0, 8'd0, -9'sd180, 16'd0, 16'd0, 8'd0};
    dir_cfg[1] = '{1'b1, 16'd0, 8'd180, 9'sd180, 16'd1, 16'd2, 8'd1};
    dir_cfg[2] = '{1'b0, 16'hFFFF, 8'd255, 9'sd0, 16'hFFFF, 16'hFFFF, 8'd255};
    dir_cfg[3] = '{1'b1, 16'd2, 8'd200, -9'sd1, 16'd0, 16'd1, 8'd255};

    // reset settings: center, hold and hold saturation
    add_tick(MODE_CENTER, 8'd0, 1'b0, CHK_ANGLE, 8'd90);
    add_tick(MODE_HOLD, 8'd0, 1'b0, CHK_ANGLE, 8'd0);
    add_tick(MODE_HOLD, 8'd180, 1'b0, CHK_ANGLE, 8'd180);
    add_tick(MODE_HOLD, 8'd255, 1'b0, CHK_ANGLE, 8'd180);
    add_tick(MODE_HOLD, 8'd181, 1'b1, CHK_ANGLE, 8'd180);
    // wag sides saturate, zero wag limit gives only centre pauses
    add_program(0);
    add_tick(MODE_WAG, 8'd0, 1'b0, CHK_ANGLE, 8'd0);
    add_tick(MODE_WAG, 8'd0, 1'b0, CHK_ANGLE, 8'd180);
    add_tick(MODE_INTERVAL, 8'd0, 1'b0, CHK_ANGLE, 8'd0);
    add_tick(MODE_INTERVAL, 8'd0, 1'b1, CHK_ANGLE, 8'd0);
    add_tick(MODE_CENTER, 8'd0, 1'b0, CHK_ANGLE, 8'd0);
    // burst end and wag countdown still running
    add_program(1);
    add_tick(MODE_INTERVAL, 8'd0, 1'b0, CHK_MODEL, 8'd0);
    add_tick(MODE_INTERVAL, 8'd0, 1'b0, CHK_MODEL, 8'd0);
    add_tick(MODE_INTERVAL, 8'd0, 1'b0, CHK_MODEL, 8'd0);
    add_tick(MODE_INTERVAL, 8'd0, 1'b0, CHK_MODEL, 8'd0);
    add_tick(MODE_INTERVAL, 8'd0, 1'b1, CHK_MODEL, 8'd0);
    add_tick(MODE_WAG, 8'd0, 1'b0, CHK_MODEL, 8'd0);
    // disabled
    add_program(2);
    add_tick(MODE_HOLD, 8'd90, 1'b0, CHK_SILENT, 8'd0);
    add_tick(MODE_WAG, 8'd0, 1'b0, CHK_SILENT, 8'd0);
    add_tick(MODE_CENTER, 8'd0, 1'b0, CHK_SILENT, 8'd0);
    // update countdown skips ticks, out-of-range centre
    add_program(3);
    add_tick(MODE_CENTER, 8'd0, 1'b0, CHK_MODEL, 8'd0);
    add_tick(MODE_HOLD, 8'd7, 1'b0, CHK_MODEL, 8'd0);
    add_tick(MODE_HOLD, 8'd7, 1'b0, CHK_MODEL, 8'd0);
    add_tick(MODE_INTERVAL, 8'd0, 1'b0, CHK_MODEL, 8'd0);
    add_tick(MODE_WAG, 8'd0, 1'b1, CHK_MODEL, 8'd0);
    add_tick(MODE_HOLD, 8'd255, 1'b0, CHK_MODEL, 8'd0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.kind == ROW_PROGRAM) begin
        program_regs(dir_cfg[r.cfg_id]);
      end else begin
        send_tick(r.mode, r.hold, r.restart, r.chk, r.angle);
      end
    end

    for (int p = 0; p < RandomPhases; p++) begin
      program_regs(draw_cfg());
      in_idle_on  = (p % 4) < 2;
      out_idle_on = (p % 2) == 0;
      n = 0;
      while (n < ItemsPerPhase) begin
        case ($urandom_range(0, 5))
          0:       run_mode = MODE_CENTER;
          1:       run_mode = MODE_HOLD;
          2, 3:    run_mode = MODE_WAG;
          default: run_mode = MODE_INTERVAL;
        endcase
        run_len = $urandom_range(4, 20);
        for (k = 0; k < run_len && n < ItemsPerPhase; k++) begin
          m = ($urandom_range(0, 9) == 0) ? ModeW'($urandom_range(0, 3)) : run_mode;
          send_tick(m, AngleW'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0),
                    CHK_MODEL, '0);
          n++;
        end
      end
    end

    settle();
    $display("covered %0d ticks, %0d servo angles checked, %0d register settings",
             ticks_seen, angles_checked, settings_used);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
